FILE: rtl/dpd_pkg.sv
package dpd_pkg;

  // Largest payload length the deframer ever accepts
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam logic [10:0] MAX_LEN_RESET = 11'(MAX_PAYLOAD);

  // Marker bytes
  localparam logic [7:0] CH_GT   = 8'h3e;  // '>'
  localparam logic [7:0] CH_STAR = 8'h2a;  // '*'
  localparam logic [7:0] CH_LT   = 8'h3c;  // '<'
  localparam logic [7:0] CH_HASH = 8'h23;  // '#'

  localparam logic [15:0] CRC_INIT = 16'h00ff;

  typedef enum logic [3:0] {
    PH_START1 = 4'd0,
    PH_START2 = 4'd1,
    PH_START3 = 4'd2,
    PH_LEN_LO = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_TYPE   = 4'd5,
    PH_DATA   = 4'd6,
    PH_CRC_LO = 4'd7,
    PH_CRC_HI = 4'd8,
    PH_END1   = 4'd9,
    PH_END2   = 4'd10,
    PH_END3   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MARKER = 2'd1,
    ERR_LENGTH = 2'd2
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  packet_kind;
    logic [10:0] payload_length;
    logic [15:0] received_crc;
    logic        crc_ok;
    err_t        error_code;
    logic        last;
  } dpd_result_t;

  // Input holding stage as seen by the core
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } dpd_stage_t;

  // Reflected CCITT byte update
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage

FILE: rtl/dpd_if.sv
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpd_out_if;
  logic                 valid;
  logic                 ready;
  dpd_pkg::dpd_result_t res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

interface dpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] max_length;
  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

FILE: rtl/dpd_in_reg.sv
module dpd_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  dpd_in_if.sink              in_ch,
  input  logic                advance,
  output dpd_pkg::dpd_stage_t stage
);
  import dpd_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  // Room when empty or when the held byte moves on this cycle
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.rx_byte = byte_r;

endmodule

FILE: rtl/dpd_core.sv
module dpd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  dpd_cfg_if.sink              cfg_ch,
  input  dpd_pkg::dpd_stage_t  stage,
  input  logic                 advance,
  output logic                 res_valid,
  output dpd_pkg::dpd_result_t res
);
  import dpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [10:0] max_length_r;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [10:0] frame_len_r, frame_len_nxt;
  logic [10:0] count_r, count_nxt;
  logic [7:0]  frame_type_r, frame_type_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] carried_r, carried_nxt;

  logic [7:0]  b;
  logic [15:0] len16;
  logic        len_bad;
  logic [10:0] count_inc;
  logic        is_last;

  assign b         = stage.rx_byte;
  assign len16     = {b, len_lo_r};
  assign len_bad   = (len16 == 16'd0) || (len16 > {5'b0, max_length_r}) ||
                     (len16 > 16'(MAX_PAYLOAD));
  assign count_inc = count_r + 11'd1;
  assign is_last   = count_inc >= frame_len_r;

  // Configuration register; the user should write it only while idle, the block does not enforce it
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_length_r <= cfg_ch.max_length;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_START2: phase_nxt = (b == CH_STAR) ? PH_START3 : PH_START1;
      PH_START3: phase_nxt = (b == CH_GT) ? PH_LEN_LO : PH_START1;
      PH_LEN_LO: phase_nxt = PH_LEN_HI;
      PH_LEN_HI: phase_nxt = len_bad ? PH_START1 : PH_TYPE;
      PH_TYPE:   phase_nxt = PH_DATA;
      PH_DATA:   phase_nxt = is_last ? PH_CRC_LO : PH_DATA;
      PH_CRC_LO: phase_nxt = PH_CRC_HI;
      PH_CRC_HI: phase_nxt = PH_END1;
      PH_END1:   phase_nxt = (b == CH_LT) ? PH_END2 : PH_START1;
      PH_END2:   phase_nxt = (b == CH_HASH) ? PH_END3 : PH_START1;
      PH_END3:   phase_nxt = PH_START1;
      default:   phase_nxt = (b == CH_GT) ? PH_START2 : PH_START1;
    endcase
  end

  // Frame fields and result for the current byte
  always_comb begin
    len_lo_nxt     = len_lo_r;
    frame_len_nxt  = frame_len_r;
    count_nxt      = count_r;
    frame_type_nxt = frame_type_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    carried_nxt    = carried_r;

    res_valid          = 1'b0;
    res.kind           = KIND_ERROR;
    res.data_byte      = 8'd0;
    res.packet_kind    = frame_type_r;
    res.payload_length = 11'd0;
    res.received_crc   = 16'd0;
    res.crc_ok         = 1'b0;
    res.error_code     = ERR_NONE;
    res.last           = 1'b0;

    unique case (phase_r)
      PH_START2, PH_START3: begin
        if (b != ((phase_r == PH_START2) ? CH_STAR : CH_GT)) begin
          res_valid      = 1'b1;
          res.error_code = ERR_MARKER;
        end
      end
      PH_LEN_LO: len_lo_nxt = b;
      PH_LEN_HI: begin
        frame_len_nxt = len16[10:0];
        if (len_bad) begin
          res_valid      = 1'b1;
          res.error_code = ERR_LENGTH;
        end
      end
      PH_TYPE: begin
        frame_type_nxt = b;
        crc_nxt        = CRC_INIT;
        count_nxt      = 11'd0;
      end
      PH_DATA: begin
        crc_nxt            = crc_step(crc_r, b);
        count_nxt          = count_inc;
        res_valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.data_byte      = b;
        res.payload_length = frame_len_r;
        res.last           = is_last;
      end
      PH_CRC_LO: crc_lo_nxt  = b;
      PH_CRC_HI: carried_nxt = {b, crc_lo_r};
      PH_END1, PH_END2: begin
        if (b != ((phase_r == PH_END1) ? CH_LT : CH_HASH)) begin
          res_valid      = 1'b1;
          res.error_code = ERR_MARKER;
        end
      end
      PH_END3: begin
        res_valid = 1'b1;
        if (b != CH_LT) begin
          res.error_code = ERR_MARKER;
        end else begin
          res.kind           = KIND_DONE;
          res.payload_length = frame_len_r;
          res.received_crc   = carried_r;
          res.crc_ok         = (crc_r == carried_r);
        end
      end
      default: ;
    endcase
  end

  // State update when a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START1;
      len_lo_r     <= 8'd0;
      frame_len_r  <= 11'd0;
      count_r      <= 11'd0;
      frame_type_r <= 8'd0;
      crc_r        <= CRC_INIT;
      crc_lo_r     <= 8'd0;
      carried_r    <= 16'd0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      len_lo_r     <= len_lo_nxt;
      frame_len_r  <= frame_len_nxt;
      count_r      <= count_nxt;
      frame_type_r <= frame_type_nxt;
      crc_r        <= crc_nxt;
      crc_lo_r     <= crc_lo_nxt;
      carried_r    <= carried_nxt;
    end
  end

endmodule

FILE: rtl/dpd_out_reg.sv
module dpd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 res_valid,
  input  dpd_pkg::dpd_result_t res,
  output logic                 room,
  dpd_out_if.source            out_ch
);
  import dpd_pkg::*;

  logic        valid_r;
  dpd_result_t res_r;

  // Free when empty or drained this cycle
  assign room = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.res   = res_r;

endmodule

FILE: rtl/delimited_packet_deframer_crc16.sv
// Channel  | Dir | Payload                                    | Request when
// ---------+-----+--------------------------------------------+-------------------
// in_ch    | in  | rx_byte                                    | valid && ready
// out_ch   | out | res: kind, data_byte, packet_kind, ...     | valid && ready
// cfg_ch   | in  | max_length                                 | valid && ready
//
// One byte per cycle sustained while out_ch is ready; a byte's result passes the input
// register, then the state step into the output register; a stall can hold it between.
// The phase step and the byte-wide CRC update sit between those two registers.
// Synchronous active-low reset returns to hunting with max_length at 1024.
// A stalled output holds its result while the input register takes one more byte.
module delimited_packet_deframer_crc16 (
  input  logic      clk,
  input  logic      rst_n,
  dpd_in_if.sink    in_ch,
  dpd_out_if.source out_ch,
  dpd_cfg_if.sink   cfg_ch
);
  import dpd_pkg::*;

  dpd_stage_t  stage;
  logic        advance;
  logic        room;
  logic        res_valid;
  dpd_result_t res;

  // Held byte moves into the core when the output side has room
  assign advance = stage.valid && room;

  dpd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  dpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .stage     (stage),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  dpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stage.valid)
    else $error("input stalled with empty holding register");

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> stage.valid)
    else $error("accepted byte not held");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.res.kind == KIND_ERROR) == (out_ch.res.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  a_crc_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.res.crc_ok |-> out_ch.res.kind == KIND_DONE)
    else $error("crc_ok set outside a frame-complete result");
`endif

endmodule

FILE: sim/delimited_packet_deframer_crc16_tb.sv
`timescale 1ns / 1ps

module delimited_packet_deframer_crc16_tb;
  import dpd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL    = 400;

  // Ways a generated frame can be damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_LENGTH,
    FLAW_TRUNCATE,
    FLAW_CRC,
    FLAW_END
  } flaw_t;

  // Tracks the deframer state and holds the results still owed by the block
  class deframe_scoreboard;
    logic [10:0] max_len;
    phase_t      ph;
    logic [15:0] frame_len;
    logic [10:0] count;
    logic [7:0]  ftype;
    logic [15:0] crc_run;
    logic [15:0] crc_rx;
    dpd_result_t owed_results[$];
    int          mismatches;

    function new();
      max_len    = MAX_LEN_RESET;
      ph         = PH_START1;
      frame_len  = '0;
      count      = '0;
      ftype      = '0;
      crc_run    = CRC_INIT;
      crc_rx     = '0;
      mismatches = 0;
    endfunction

    // Reflected CCITT update over one byte
    static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [7:0]  d;
      logic [15:0] dw;
      d  = b ^ crc[7:0];
      d  = d ^ (d << 4);
      dw = {8'h00, d};
      return {d, crc[15:8]} ^ (dw >> 4) ^ (dw << 3);
    endfunction

    function dpd_result_t frame_error(err_t code);
      dpd_result_t r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      ph           = PH_START1;
      return r;
    endfunction

    // Step the tracked state by one accepted byte
    function void take_byte(logic [7:0] b);
      dpd_result_t r;
      bit          hit;
      r   = '0;
      hit = 1'b0;
      case (ph)
        PH_START2: begin
          if (b != CH_STAR) begin
            r   = frame_error(ERR_MARKER);
            hit = 1'b1;
          end else ph = PH_START3;
        end
        PH_START3: begin
          if (b != CH_GT) begin
            r   = frame_error(ERR_MARKER);
            hit = 1'b1;
          end else ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len = {8'h00, b};
          ph        = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_len = {b, frame_len[7:0]};
          if (frame_len == 0 || frame_len > max_len || frame_len > MAX_PAYLOAD) begin
            r   = frame_error(ERR_LENGTH);
            hit = 1'b1;
          end else ph = PH_TYPE;
        end
        PH_TYPE: begin
          ftype   = b;
          crc_run = CRC_INIT;
          count   = '0;
          ph      = PH_DATA;
        end
        PH_DATA: begin
          crc_run          = crc16_update(crc_run, b);
          count            = count + 11'd1;
          r.kind           = KIND_DATA;
          r.data_byte      = b;
          r.payload_length = frame_len[10:0];
          r.last           = ({5'd0, count} >= frame_len);
          if (r.last) ph = PH_CRC_LO;
          hit = 1'b1;
        end
        PH_CRC_LO: begin
          crc_rx = {8'h00, b};
          ph     = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc_rx = {b, crc_rx[7:0]};
          ph     = PH_END1;
        end
        PH_END1: begin
          if (b != CH_LT) begin
            r   = frame_error(ERR_MARKER);
            hit = 1'b1;
          end else ph = PH_END2;
        end
        PH_END2: begin
          if (b != CH_HASH) begin
            r   = frame_error(ERR_MARKER);
            hit = 1'b1;
          end else ph = PH_END3;
        end
        PH_END3: begin
          if (b != CH_LT) begin
            r = frame_error(ERR_MARKER);
          end else begin
            ph               = PH_START1;
            r.kind           = KIND_DONE;
            r.payload_length = frame_len[10:0];
            r.received_crc   = crc_rx;
            r.crc_ok         = (crc_run == crc_rx);
          end
          hit = 1'b1;
        end
        default: ph = (b == CH_GT) ? PH_START2 : PH_START1;
      endcase
      if (hit) begin
        r.packet_kind = ftype;
        owed_results.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(dpd_result_t got);
      dpd_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result with none expected, actual kind %0d data %0h err %0d",
                 $time, got.kind, got.data_byte, got.error_code);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("packet_kind", want.packet_kind, got.packet_kind);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("received_crc", want.received_crc, got.received_crc);
      compare_field("crc_ok", want.crc_ok, got.crc_ok);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dpd_in_if  in_ch ();
  dpd_out_if out_ch ();
  dpd_cfg_if cfg_ch ();

  delimited_packet_deframer_crc16 i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deframe_scoreboard sb;
  logic [7:0]        tx_bytes[$];
  int                send_idle_pct  = 0;
  int                recv_idle_pct  = 0;
  int                stall_requests = 0;
  int                stall_served   = 0;
  int                stall_left     = 0;
  int                cycle_count    = 0;

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: check each request, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.res);
    if (stall_served != stall_requests) begin
      stall_served++;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] other_than(logic [7:0] want);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == want) b = ~want;
    return b;
  endfunction

  // Queue one frame, possibly damaged; fill < 0 gives random payload
  function automatic void add_frame(int len, logic [7:0] type_byte, flaw_t flaw,
                                    int fill = -1);
    logic [15:0] len16;
    logic [15:0] crc;
    logic [7:0]  b;
    int          spot;
    int          n;
    len16 = 16'(len);
    spot  = $urandom_range(2);
    tx_bytes.push_back(CH_GT);
    tx_bytes.push_back((flaw == FLAW_START && spot != 2) ? other_than(CH_STAR) : CH_STAR);
    tx_bytes.push_back((flaw == FLAW_START && spot == 2) ? other_than(CH_GT) : CH_GT);
    tx_bytes.push_back(len16[7:0]);
    tx_bytes.push_back(len16[15:8]);
    if (flaw == FLAW_LENGTH) begin
      repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    tx_bytes.push_back(type_byte);
    crc = CRC_INIT;
    n   = (flaw == FLAW_TRUNCATE) ? len / 2 : len;
    for (int i = 0; i < n; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      crc = deframe_scoreboard::crc16_update(crc, b);
      tx_bytes.push_back(b);
    end
    if (flaw == FLAW_TRUNCATE) return;
    if (flaw == FLAW_CRC) crc ^= 16'(1 << $urandom_range(15));
    tx_bytes.push_back(crc[7:0]);
    tx_bytes.push_back(crc[15:8]);
    tx_bytes.push_back((flaw == FLAW_END && spot == 0) ? other_than(CH_LT) : CH_LT);
    tx_bytes.push_back((flaw == FLAW_END && spot == 1) ? other_than(CH_HASH) : CH_HASH);
    tx_bytes.push_back((flaw == FLAW_END && spot == 2) ? other_than(CH_LT) : CH_LT);
  endfunction

  // Mostly clean frames with random content, plus damaged frames and line noise
  function automatic void add_random_traffic(int n_bytes);
    int target;
    int eff;
    int lim;
    int pick;
    int len;
    target = tx_bytes.size() + n_bytes;
    eff    = (sb.max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(sb.max_len);
    lim    = (eff == 0) ? 3 : ((eff > 40) ? 40 : eff);
    while (tx_bytes.size() < target) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(7) == 0) ? $urandom_range(1, lim)
                                      : $urandom_range(1, (lim > 8) ? 8 : lim);
      if (pick < 60) add_frame(len, 8'($urandom_range(255)), FLAW_NONE);
      else if (pick < 67) add_frame(len, 8'($urandom_range(255)), FLAW_CRC);
      else if (pick < 74) add_frame(len, 8'($urandom_range(255)), FLAW_END);
      else if (pick < 80) add_frame(len, 8'($urandom_range(255)), FLAW_START);
      else if (pick < 86) begin
        case ($urandom_range(2))
          0:       len = 0;
          1:       len = eff + 1 + $urandom_range(3);
          default: len = 16'hffff;
        endcase
        add_frame(len, 8'($urandom_range(255)), FLAW_LENGTH);
      end else if (pick < 92) add_frame(len, 8'($urandom_range(255)), FLAW_TRUNCATE);
      else begin
        repeat ($urandom_range(1, 4))
          tx_bytes.push_back(($urandom_range(3) == 0) ? CH_GT : 8'($urandom_range(255)));
      end
    end
  endfunction

  // Offer queued bytes one request at a time
  task automatic send_all();
    logic [7:0] b;
    while (tx_bytes.size() > 0) begin
      b = tx_bytes.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'($urandom_range(255));
        @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.rx_byte <= b;
      do @(posedge clk); while (!in_ch.ready);
      sb.take_byte(b);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_max_length(logic [10:0] v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.max_len = v;
  endtask

  // Drain owed results, then cover bytes still in the pipeline
  task automatic settle();
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.max_length = 11'd0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles less than receiver
    send_idle_pct = 33;
    recv_idle_pct = 59;

    // Directed: noise while hunting, bad start bytes, bad lengths, 1-byte frame
    write_max_length(MAX_LEN_RESET);
    tx_bytes = '{8'h00, CH_GT, 8'h00, CH_GT, CH_STAR, 8'hff,
                 CH_GT, CH_STAR, CH_GT, 8'h00, 8'h00};
    add_frame(MAX_PAYLOAD + 1, 8'h5a, FLAW_LENGTH);
    add_frame(1, 8'hff, FLAW_NONE, 8'hff);
    send_all();
    settle();

    // Smallest useful limit: only 1-byte frames pass
    write_max_length(11'd1);
    add_random_traffic(60);
    send_all();
    settle();

    // Receiver idles less than sender
    send_idle_pct = 59;
    recv_idle_pct = 33;

    // Long frame, with a long hold-off on the result side
    write_max_length(MAX_LEN_RESET);
    stall_requests++;
    add_frame(48, 8'h81, FLAW_NONE);
    add_random_traffic(50);
    send_all();
    settle();

    write_max_length(11'd300);
    add_random_traffic(90);
    send_all();
    settle();

    // No idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Limit above the payload ceiling: the ceiling still applies
    write_max_length(11'h7ff);
    add_frame(MAX_PAYLOAD + 1, 8'h3c, FLAW_LENGTH);
    add_random_traffic(60);
    send_all();
    settle();

    // Zero limit rejects every frame
    write_max_length(11'd0);
    add_random_traffic(40);
    send_all();
    settle();

    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dpd_pkg.sv
rtl/dpd_if.sv
rtl/dpd_in_reg.sv
rtl/dpd_core.sv
rtl/dpd_out_reg.sv
rtl/delimited_packet_deframer_crc16.sv
sim/delimited_packet_deframer_crc16_tb.sv
